@@ design/rfpc_pkg.sv @@
// Shared types, codes and a helper function for the RFB pixel format converter.
package rfpc_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_PALETTE  = 2'd0,
		MODE_RGB565   = 2'd1,
		MODE_XRGB8888 = 2'd2
	} src_mode_t;

	typedef enum logic {
		ACT_CONVERT   = 1'b0,
		ACT_PAL_WRITE = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		CFG_SOURCE_MODE    = 3'd0,
		CFG_CLIENT_BYTES   = 3'd1,
		CFG_CHANNEL_WIDTHS = 3'd2,
		CFG_RED_POSITION   = 3'd3,
		CFG_GREEN_POSITION = 3'd4,
		CFG_BLUE_POSITION  = 3'd5,
		CFG_CLIENT_BIG_END = 3'd6,
		CFG_SWAP_SOURCE    = 3'd7
	} cfg_reg_t;

	localparam int CFG_DATA_W = 12;

	typedef struct packed {
		src_mode_t   source_mode;
		logic [2:0]  client_bytes;
		logic [11:0] channel_widths;
		logic [4:0]  red_position;
		logic [4:0]  green_position;
		logic [4:0]  blue_position;
		logic        client_big_endian;
		logic        swap_source;
	} cfg_t;

	typedef struct packed {
		logic       last;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] cut_channel(input logic [7:0] v, input logic [3:0] w);
		logic [3:0] w_c;
		w_c = (w > 4'd8) ? 4'd8 : w;
		if (w_c == 4'd0) begin
			return 8'd0;
		end
		return v >> (4'd8 - w_c);
	endfunction

endpackage

@@ design/rfpc_if.sv @@
// Valid/ready channel interfaces for pixel items and client pixel beats.
interface rfpc_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] source_pixel;
	logic [7:0]  palette_slot;
	logic [23:0] palette_color;
	logic        last_in_row;

	modport source(output valid, action, source_pixel, palette_slot, palette_color,
		last_in_row, input ready);
	modport sink(input valid, action, source_pixel, palette_slot, palette_color,
		last_in_row, output ready);
endinterface

interface rfpc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] wire_bytes;
	logic [2:0]  byte_count;
	logic        last_out;

	modport source(output valid, wire_bytes, byte_count, last_out, input ready);
	modport sink(input valid, wire_bytes, byte_count, last_out, output ready);
endinterface

@@ design/rfpc_front.sv @@
// Front end: accepts beats, owns the palette store and decodes the source pixel to RGB888.
module rfpc_front #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	rfpc_in_if.sink             pix_in,
	input  rfpc_pkg::cfg_t      cfg,
	output rfpc_pkg::item_t     item,
	output logic                push,
	input  logic                full
);

	localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0] DEPTH = 9'(PALETTE_ENTRIES);

	logic [23:0] mem [PALETTE_ENTRIES];

	logic        accept;
	logic        is_convert;
	logic        valid_s1;
	logic [23:0] colour_s1;
	logic        hit_s1;
	logic [15:0] src_s1;
	logic [23:0] xrgb_s1;
	logic        last_s1;

	assign is_convert   = (rfpc_pkg::action_t'(pix_in.action) == rfpc_pkg::ACT_CONVERT);
	assign pix_in.ready = !valid_s1 || !full;
	assign accept       = pix_in.valid && pix_in.ready;
	assign push         = valid_s1 && !full;

	always_ff @(posedge clk) begin
		if (accept && !is_convert && ({1'b0, pix_in.palette_slot} < DEPTH)) begin
			mem[pix_in.palette_slot[AW-1:0]] <= pix_in.palette_color;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_convert) begin
			colour_s1 <= mem[pix_in.source_pixel[AW-1:0]];
			hit_s1    <= ({1'b0, pix_in.source_pixel[7:0]} < DEPTH);
			src_s1    <= pix_in.source_pixel[15:0];
			xrgb_s1   <= pix_in.source_pixel[23:0];
			last_s1   <= pix_in.last_in_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= accept && is_convert;
		end
	end

	always_comb begin
		logic [15:0] p;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		p = cfg.swap_source ? {src_s1[7:0], src_s1[15:8]} : src_s1;
		r = 8'd0;
		g = 8'd0;
		b = 8'd0;
		case (cfg.source_mode)
			rfpc_pkg::MODE_PALETTE: begin
				if (hit_s1) begin
					r = colour_s1[23:16];
					g = colour_s1[15:8];
					b = colour_s1[7:0];
				end
			end
			rfpc_pkg::MODE_RGB565: begin
				r = {p[15:11], 3'b000};
				g = {p[10:5], 2'b00};
				b = {p[4:0], 3'b000};
			end
			rfpc_pkg::MODE_XRGB8888: begin
				r = xrgb_s1[23:16];
				g = xrgb_s1[15:8];
				b = xrgb_s1[7:0];
			end
			default: begin
				r = 8'd0;
				g = 8'd0;
				b = 8'd0;
			end
		endcase
		item.last  = last_s1;
		item.green = g;
		item.red   = cfg.swap_source ? b : r;
		item.blue  = cfg.swap_source ? r : b;
	end

endmodule

@@ design/rfpc_queue.sv @@
// Short queue of decoded pixels between front and back end.
module rfpc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rfpc_pkg::item_t       push_item,
	input  logic                  pop,
	output rfpc_pkg::item_t       head,
	output rfpc_pkg::q_status_t   status
);

	rfpc_pkg::item_t                 entries_q [rfpc_pkg::QUEUE_DEPTH];
	logic [rfpc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [rfpc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [rfpc_pkg::QCNT_W-1:0]     count_q;

	assign head         = entries_q[rd_ptr_q];
	assign status.full  = (count_q == rfpc_pkg::QCNT_W'(rfpc_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/rfpc_back.sv @@
// Back end: cuts and places channels, orders client bytes and holds the output beat.
module rfpc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rfpc_pkg::cfg_t      cfg,
	input  rfpc_pkg::item_t     head,
	input  logic                empty,
	output logic                pop,
	rfpc_out_if.source          pix_out
);

	logic        valid_q;
	logic [31:0] wire_bytes_q;
	logic [2:0]  byte_count_q;
	logic        last_q;
	logic [31:0] wire_d;
	logic [2:0]  n_d;

	assign pop                = !empty && (!valid_q || pix_out.ready);
	assign pix_out.valid      = valid_q;
	assign pix_out.wire_bytes = wire_bytes_q;
	assign pix_out.byte_count = byte_count_q;
	assign pix_out.last_out   = last_q;

	always_comb begin
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [31:0] pixel;
		logic [1:0]  from;
		r = rfpc_pkg::cut_channel(head.red, cfg.channel_widths[11:8]);
		g = rfpc_pkg::cut_channel(head.green, cfg.channel_widths[7:4]);
		b = rfpc_pkg::cut_channel(head.blue, cfg.channel_widths[3:0]);
		pixel = (32'(r) << cfg.red_position) | (32'(g) << cfg.green_position) |
			(32'(b) << cfg.blue_position);
		if (cfg.client_bytes == 3'd0) begin
			n_d = 3'd1;
		end else if (cfg.client_bytes > 3'd4) begin
			n_d = 3'd4;
		end else begin
			n_d = cfg.client_bytes;
		end
		wire_d = 32'd0;
		for (int k = 0; k < 4; k++) begin
			from = cfg.client_big_endian ? 2'(n_d - 3'd1 - 3'(k)) : 2'(k);
			if (3'(k) < n_d) begin
				wire_d[8*k +: 8] = pixel[8*from +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wire_bytes_q <= wire_d;
			byte_count_q <= n_d;
			last_q       <= head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || pix_out.ready) begin
			valid_q <= pop;
		end
	end

endmodule

@@ design/rfb_pixel_format_converter_top.sv @@
// A converted pixel passes through the front-end register, the queue and the output register to pix_out.
// Throughput: one beat per cycle while the queue and pix_out do not stall; a palette write yields no beat.
// The palette store takes one write or one read per cycle, as each accepted beat is a write or a convert.
// Reset clears handshake state and loads register defaults (xrgb8888, 4 bytes, 8/8/8 at 16/8/0).
// The palette store is not cleared; an entry holds no defined colour until it has been written.
module rfb_pixel_format_converter_top #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [rfpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	rfpc_in_if.sink                           pix_in,
	rfpc_out_if.source                        pix_out
);

	rfpc_pkg::cfg_t      cfg_q;
	rfpc_pkg::item_t     front_item;
	rfpc_pkg::item_t     q_head;
	rfpc_pkg::q_status_t q_status;
	logic                q_push;
	logic                q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_mode       <= rfpc_pkg::MODE_XRGB8888;
			cfg_q.client_bytes      <= 3'd4;
			cfg_q.channel_widths    <= 12'h888;
			cfg_q.red_position      <= 5'd16;
			cfg_q.green_position    <= 5'd8;
			cfg_q.blue_position     <= 5'd0;
			cfg_q.client_big_endian <= 1'b0;
			cfg_q.swap_source       <= 1'b0;
		end else if (cfg_we) begin
			case (rfpc_pkg::cfg_reg_t'(cfg_index))
				rfpc_pkg::CFG_SOURCE_MODE:
					cfg_q.source_mode <= rfpc_pkg::src_mode_t'(cfg_data[1:0]);
				rfpc_pkg::CFG_CLIENT_BYTES:   cfg_q.client_bytes <= cfg_data[2:0];
				rfpc_pkg::CFG_CHANNEL_WIDTHS: cfg_q.channel_widths <= cfg_data[11:0];
				rfpc_pkg::CFG_RED_POSITION:   cfg_q.red_position <= cfg_data[4:0];
				rfpc_pkg::CFG_GREEN_POSITION: cfg_q.green_position <= cfg_data[4:0];
				rfpc_pkg::CFG_BLUE_POSITION:  cfg_q.blue_position <= cfg_data[4:0];
				rfpc_pkg::CFG_CLIENT_BIG_END: cfg_q.client_big_endian <= cfg_data[0];
				rfpc_pkg::CFG_SWAP_SOURCE:    cfg_q.swap_source <= cfg_data[0];
				default:                      cfg_q <= cfg_q;
			endcase
		end
	end

	rfpc_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.cfg    (cfg_q),
		.item   (front_item),
		.push   (q_push),
		.full   (q_status.full)
	);

	rfpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.pop       (q_pop),
		.head      (q_head),
		.status    (q_status)
	);

	rfpc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.head    (q_head),
		.empty   (q_status.empty),
		.pop     (q_pop),
		.pix_out (pix_out)
	);

	a_pal_write_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready && pix_in.action == rfpc_pkg::ACT_PAL_WRITE) |=> !q_push)
		else $error("palette write produced a queue entry");

	a_convert_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_in.valid && pix_in.ready && pix_in.action == rfpc_pkg::ACT_CONVERT) |=>
		(q_push || q_status.full))
		else $error("accepted pixel not offered to queue");

	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue both full and empty");

	a_out_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pix_out.valid) |-> $past(q_pop))
		else $error("output beat without queue pop");

endmodule
